FILE: sv/ccrt_pkg.sv
// Shared types, constants and the arctangent table of the circle transform.
`timescale 1ns / 1ps
package ccrt_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int MAX_TABLE     = 32;
    localparam int N_STAGES      = (CORDIC_STAGES < MAX_TABLE) ? CORDIC_STAGES : MAX_TABLE;

    // Widths: reduced-angle accumulator, residual angle, CORDIC vector, final sum.
    localparam int AW = 33;
    localparam int RW = 28;
    localparam int ZW = 36;
    localparam int XW = 50;
    localparam int FW = XW - 16 + 2;

    localparam longint HALF_PI_Q24 = 26353589;
    localparam longint PI_Q24      = 52707179;
    localparam longint TWO_PI_Q24  = 105414357;
    localparam longint GAIN_Q31    = 1304065748;
    // Offset that lifts every Q8.24 angle above zero while keeping it a whole number of turns.
    localparam longint ANG_OFFSET  = 21 * TWO_PI_Q24;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_RADIUS = 2'd1,
        ST_SATURATED  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] rad;
        logic               bad;
    } t_side;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_rot;

    // atan(2^-i) in Q2.30, truncated.
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        begin
            case (i)
                0:  v = 32'd843314856;
                1:  v = 32'd497837829;
                2:  v = 32'd263043836;
                3:  v = 32'd133525158;
                4:  v = 32'd67021686;
                5:  v = 32'd33543515;
                6:  v = 32'd16775850;
                7:  v = 32'd8388437;
                8:  v = 32'd4194282;
                9:  v = 32'd2097149;
                10: v = 32'd1048575;
                11: v = 32'd524287;
                12: v = 32'd262143;
                13: v = 32'd131071;
                14: v = 32'd65535;
                15: v = 32'd32767;
                16: v = 32'd16383;
                17: v = 32'd8191;
                18: v = 32'd4095;
                19: v = 32'd2047;
                20: v = 32'd1023;
                21: v = 32'd511;
                22: v = 32'd255;
                23: v = 32'd127;
                24: v = 32'd63;
                25: v = 32'd31;
                26: v = 32'd15;
                27: v = 32'd7;
                28: v = 32'd3;
                29: v = 32'd1;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: sv/circle_center_rigid_transform.sv
// Top level: rotates a circle centre about the origin and translates it, CORDIC pipelined.
// Throughput: one request per cycle while the output is not stalled; every stage is a register, so
// a new request may enter on each clock while earlier ones are still in flight.
// A stalled output holds the whole pipeline in place through one shared enable.
// Reset (synchronous, active low) clears the valid bits only; no clearing pass is needed.
`timescale 1ns / 1ps
module circle_center_rigid_transform (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [31:0]  i_center_x,
    input  logic signed [31:0]  i_center_y,
    input  logic signed [31:0]  i_radius,
    input  logic signed [31:0]  i_shift_x,
    input  logic signed [31:0]  i_shift_y,
    input  logic signed [31:0]  i_angle,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_radius,
    output logic [1:0]          o_status
);
    import ccrt_pkg::*;

    // The pipeline moves whenever the output register is empty or is being read.
    // This lets a new request in on the same cycle as a waiting result leaves.
    logic  w_en;
    t_side w_side_in;
    logic  w_red_v;
    t_rot  w_red_rot;
    t_side w_red_side;
    logic  w_cor_v;
    t_rot  w_cor_rot;
    t_side w_cor_side;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Translation and radius ride alongside the angle path; a radius of zero or
    // below is flagged here and overrides the rotated result at the end.
    always_comb begin
        w_side_in.tx  = i_shift_x;
        w_side_in.ty  = i_shift_y;
        w_side_in.rad = i_radius;
        w_side_in.bad = (i_radius <= 32'sd0);
    end

    // Five stages: offset, three stages of constant-multiple subtraction for the
    // modulo two pi, then the half-turn fold with the gain-scaled centre.
    ccrt_reduce u_reduce (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_in_valid),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_angle    (i_angle),
        .i_side     (w_side_in),
        .o_valid    (w_red_v),
        .o_rot      (w_red_rot),
        .o_side     (w_red_side)
    );

    // One rotation iteration per stage.
    ccrt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_red_v),
        .i_rot   (w_red_rot),
        .i_side  (w_red_side),
        .o_valid (w_cor_v),
        .o_rot   (w_cor_rot),
        .o_side  (w_cor_side)
    );

    // Rounding, translation and saturation land in the output register.
    ccrt_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_cor_v),
        .i_rot    (w_cor_rot),
        .i_side   (w_cor_side),
        .o_valid  (o_out_valid),
        .o_x      (o_out_x),
        .o_y      (o_out_y),
        .o_radius (o_out_radius),
        .o_status (o_status)
    );

    a_bad_radius_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_BAD_RADIUS) |-> (o_out_x == 32'sd0) && (o_out_y == 32'sd0))
        else $error("bad-radius result carries a non-zero centre");

    a_status_matches_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status == ST_BAD_RADIUS) == (o_out_radius <= 32'sd0)))
        else $error("radius status disagrees with the radius delivered");

    a_saturated_on_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_SATURATED) |->
            (o_out_x == 32'sh7fffffff) || (o_out_x == 32'sh80000000) ||
            (o_out_y == 32'sh7fffffff) || (o_out_y == 32'sh80000000))
        else $error("saturated status without a clamped coordinate");

    a_stall_freezes_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_cor_v) && $stable(w_red_v))
        else $error("pipeline moved while the output was stalled");

endmodule

FILE: sv/ccrt_reduce.sv
// Angle reduction modulo two pi, quadrant fold and CORDIC gain scaling in five stages.
`timescale 1ns / 1ps
module ccrt_reduce (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [31:0]    i_center_x,
    input  logic signed [31:0]    i_center_y,
    input  logic signed [31:0]    i_angle,
    input  ccrt_pkg::t_side       i_side,
    output logic                  o_valid,
    output ccrt_pkg::t_rot        o_rot,
    output ccrt_pkg::t_side       o_side
);
    import ccrt_pkg::*;

    localparam logic [AW-1:0]        TP      = AW'(TWO_PI_Q24);
    localparam logic signed [AW:0]   OFS     = (AW+1)'(ANG_OFFSET);
    localparam logic signed [31:0]   GAIN_S  = 32'(GAIN_Q31);
    localparam logic signed [RW-1:0] PI_R    = RW'(PI_Q24);
    localparam logic signed [RW-1:0] TP_R    = RW'(TWO_PI_Q24);
    localparam logic signed [RW-1:0] HALF_R  = RW'(HALF_PI_Q24);
    localparam logic signed [RW-1:0] NHALF_R = -RW'(HALF_PI_Q24);

    function automatic logic [AW-1:0] csub(input logic [AW-1:0] a, input logic [AW-1:0] m);
        return (a >= m) ? a - m : a;
    endfunction

    logic [4:0]          r_v;
    logic [AW-1:0]       r_a [4];
    logic signed [63:0]  r_px [4];
    logic signed [63:0]  r_py [4];
    t_side               r_side [5];
    t_rot                r_rot;

    logic signed [AW:0]   n_sum;
    logic signed [63:0]   n_px;
    logic signed [63:0]   n_py;
    logic [AW-1:0]        n_a2;
    logic [AW-1:0]        n_a3;
    logic [AW-1:0]        n_a4;
    logic signed [RW-1:0] n_r0;
    logic signed [RW-1:0] n_r1;
    logic signed [RW-1:0] n_r2;
    logic                 n_flip;
    logic signed [63:0]   n_fx;
    logic signed [63:0]   n_fy;
    logic signed [63:0]   n_sx;
    logic signed [63:0]   n_sy;
    t_rot                 n_rot;

    always_comb begin
        n_sum = $signed({i_angle[31], i_angle[31], i_angle}) + OFS;
        n_px  = i_center_x * GAIN_S;
        n_py  = i_center_y * GAIN_S;
        n_a2  = csub(csub(csub(r_a[0], TP << 6), TP << 5), TP << 4);
        n_a3  = csub(csub(r_a[1], TP << 3), TP << 2);
        n_a4  = csub(csub(r_a[2], TP << 1), TP);
    end

    // The remainder now lies in [0, two pi); bring it to (-pi, pi] and then fold
    // into the right half-plane, turning the vector by a half turn when folded.
    always_comb begin
        n_r0   = $signed({1'b0, r_a[3][RW-2:0]});
        n_r1   = (n_r0 > PI_R) ? n_r0 - TP_R : n_r0;
        n_r2   = n_r1;
        n_flip = 1'b0;
        if (n_r1 > HALF_R) begin
            n_r2   = n_r1 - PI_R;
            n_flip = 1'b1;
        end else if (n_r1 < NHALF_R) begin
            n_r2   = n_r1 + PI_R;
            n_flip = 1'b1;
        end
        n_fx    = n_flip ? -r_px[3] : r_px[3];
        n_fy    = n_flip ? -r_py[3] : r_py[3];
        n_sx    = n_fx >>> 15;
        n_sy    = n_fy >>> 15;
        n_rot.x = n_sx[XW-1:0];
        n_rot.y = n_sy[XW-1:0];
        n_rot.z = $signed({{(ZW-RW-6){n_r2[RW-1]}}, n_r2, 6'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0]    <= n_sum[AW-1:0];
            r_px[0]   <= n_px;
            r_py[0]   <= n_py;
            r_side[0] <= i_side;
            r_a[1]    <= n_a2;
            r_a[2]    <= n_a3;
            r_a[3]    <= n_a4;
            for (int k = 1; k < 4; k++) begin
                r_px[k] <= r_px[k-1];
                r_py[k] <= r_py[k-1];
            end
            for (int k = 1; k < 5; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_rot <= n_rot;
        end
    end

    assign o_valid = r_v[4];
    assign o_rot   = r_rot;
    assign o_side  = r_side[4];

endmodule

FILE: sv/ccrt_cordic.sv
// Pipelined CORDIC rotation, one register stage per iteration.
`timescale 1ns / 1ps
module ccrt_cordic (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  ccrt_pkg::t_rot    i_rot,
    input  ccrt_pkg::t_side   i_side,
    output logic              o_valid,
    output ccrt_pkg::t_rot    o_rot,
    output ccrt_pkg::t_side   o_side
);
    import ccrt_pkg::*;

    logic [N_STAGES-1:0] r_v;
    t_rot                r_rot  [N_STAGES];
    t_side               r_side [N_STAGES];

    for (genvar g = 0; g < N_STAGES; g++) begin : g_stage
        t_rot                 w_in;
        t_side                w_sin;
        logic                 w_vin;
        logic signed [XW-1:0] w_dx;
        logic signed [XW-1:0] w_dy;
        logic signed [ZW-1:0] w_at;
        t_rot                 n_rot;

        if (g == 0) begin : g_first
            assign w_in  = i_rot;
            assign w_sin = i_side;
            assign w_vin = i_valid;
        end else begin : g_next
            assign w_in  = r_rot[g-1];
            assign w_sin = r_side[g-1];
            assign w_vin = r_v[g-1];
        end

        // Rotate towards a zero residual angle.
        always_comb begin
            w_dx = $signed(w_in.y) >>> g;
            w_dy = $signed(w_in.x) >>> g;
            w_at = $signed({{(ZW-32){1'b0}}, atan_q30(g)});
            if (!w_in.z[ZW-1]) begin
                n_rot.x = w_in.x - w_dx;
                n_rot.y = w_in.y + w_dy;
                n_rot.z = w_in.z - w_at;
            end else begin
                n_rot.x = w_in.x + w_dx;
                n_rot.y = w_in.y - w_dy;
                n_rot.z = w_in.z + w_at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rot[g]  <= n_rot;
                r_side[g] <= w_sin;
            end
        end
    end

    assign o_valid = r_v[N_STAGES-1];
    assign o_rot   = r_rot[N_STAGES-1];
    assign o_side  = r_side[N_STAGES-1];

endmodule

FILE: sv/ccrt_finish.sv
// Rounding to Q16.16, translation, saturation and the output register.
`timescale 1ns / 1ps
module ccrt_finish (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  ccrt_pkg::t_rot      i_rot,
    input  ccrt_pkg::t_side     i_side,
    output logic                o_valid,
    output logic signed [31:0]  o_x,
    output logic signed [31:0]  o_y,
    output logic signed [31:0]  o_radius,
    output logic [1:0]          o_status
);
    import ccrt_pkg::*;

    localparam logic signed [XW-1:0] HALF_LSB = XW'(32768);
    localparam logic signed [FW-1:0] MAX_F    = FW'(32'h7fffffff);
    localparam logic signed [FW-1:0] MIN_F    = -FW'(64'h80000000);

    logic               r_valid;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_radius;
    t_status            r_status;

    logic signed [XW-1:0] n_xr;
    logic signed [XW-1:0] n_yr;
    logic signed [FW-1:0] n_xs;
    logic signed [FW-1:0] n_ys;
    logic signed [31:0]   n_x;
    logic signed [31:0]   n_y;
    logic                 n_sat_x;
    logic                 n_sat_y;
    t_status              n_status;

    always_comb begin
        n_xr = (i_rot.x + HALF_LSB) >>> 16;
        n_yr = (i_rot.y + HALF_LSB) >>> 16;
        n_xs = $signed({{2{n_xr[XW-17]}}, n_xr[XW-17:0]})
             + $signed({{(FW-32){i_side.tx[31]}}, i_side.tx});
        n_ys = $signed({{2{n_yr[XW-17]}}, n_yr[XW-17:0]})
             + $signed({{(FW-32){i_side.ty[31]}}, i_side.ty});
        n_sat_x = (n_xs > MAX_F) || (n_xs < MIN_F);
        n_sat_y = (n_ys > MAX_F) || (n_ys < MIN_F);
        n_x = (n_xs > MAX_F) ? 32'sh7fffffff : (n_xs < MIN_F) ? 32'sh80000000 : n_xs[31:0];
        n_y = (n_ys > MAX_F) ? 32'sh7fffffff : (n_ys < MIN_F) ? 32'sh80000000 : n_ys[31:0];
        n_status = (n_sat_x || n_sat_y) ? ST_SATURATED : ST_OK;
        if (i_side.bad) begin
            n_x      = '0;
            n_y      = '0;
            n_status = ST_BAD_RADIUS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x      <= n_x;
            r_y      <= n_y;
            r_radius <= i_side.rad;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_radius = r_radius;
    assign o_status = r_status;

endmodule
